/* src/assert_macros.svh */
// assertion helpers shared by the executor rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define FCW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define FCW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* src/fcw_pkg.sv */
// shared types, codes and character helpers of the word machine executor
// no dependencies; imported by every module of the block
`default_nettype none

package fcw_pkg;

   localparam int STORE_WORDS_DEF = 100;
   localparam int ADDR_W          = 7;
   localparam int WORD_W          = 32;
   localparam int PTR_W           = 8;
   localparam int CNT_W           = 3;
   localparam int ST_W            = 3;

   // character codes
   localparam logic [7:0] CHR_NUL  = 8'h00;
   localparam logic [7:0] CHR_NL   = 8'h0A;
   localparam logic [7:0] CHR_ZERO = 8'h30;
   localparam logic [7:0] CHR_NINE = 8'h39;
   localparam logic [7:0] CHR_B    = 8'h42;
   localparam logic [7:0] CHR_C    = 8'h43;
   localparam logic [7:0] CHR_D    = 8'h44;
   localparam logic [7:0] CHR_G    = 8'h47;
   localparam logic [7:0] CHR_H    = 8'h48;
   localparam logic [7:0] CHR_L    = 8'h4C;
   localparam logic [7:0] CHR_P    = 8'h50;
   localparam logic [7:0] CHR_R    = 8'h52;
   localparam logic [7:0] CHR_S    = 8'h53;
   localparam logic [7:0] CHR_T    = 8'h54;

   // a print block is ten words, the walk index ends at nine
   localparam logic [3:0]       PD_LAST   = 4'd9;
   localparam logic [PTR_W-1:0] BLOCK_STEP = 8'd10;
   localparam logic [PTR_W-1:0] PTR_MAX   = 8'hFF;

   typedef enum logic [2:0] {
      OP_NEW_JOB  = 3'd0,
      OP_LOAD     = 3'd1,
      OP_RUN      = 3'd2,
      OP_STEP     = 3'd3,
      OP_DATA     = 3'd4,
      OP_DATA_END = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_AWAIT   = 3'd1,
      ST_HALTED  = 3'd2,
      ST_END     = 3'd3,
      ST_IGNORED = 3'd4,
      ST_DROPPED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      MODE_LOAD = 2'd0,
      MODE_RUN  = 2'd1,
      MODE_WAIT = 2'd2,
      MODE_DONE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_OPER,
      S_PD,
      S_PD_END,
      S_RESP
   } state_type;

   // instructions that need a second store access
   typedef enum logic [1:0] {
      K_LR,
      K_SR,
      K_CR
   } oper_type;

   // store access request from the sequencer
   typedef struct packed {
      logic              clr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
   } store_req_type;

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= CHR_ZERO) && (ch <= CHR_NINE);
   endfunction

   // characters before the first nul (and newline when asked), bit 3 is char 0
   function automatic logic [3:0] prefix_mask(input logic [WORD_W-1:0] w,
                                              input logic stop_nl);
      logic       run;
      logic [7:0] ch;
      logic [3:0] m;
      run = 1'b1;
      m   = '0;
      for (int j = 0; j < 4; j++) begin
         ch = w[31-8*j -: 8];
         if ((ch == CHR_NUL) || (stop_nl && (ch == CHR_NL))) run = 1'b0;
         m[3-j] = run;
      end
      return m;
   endfunction

   function automatic logic [WORD_W-1:0] char_mask(input logic [3:0] m);
      return {{8{m[3]}}, {8{m[2]}}, {8{m[1]}}, {8{m[0]}}};
   endfunction

   function automatic logic [CNT_W-1:0] mask_count(input logic [3:0] m);
      return CNT_W'($countones(m));
   endfunction

   // true when the last kept character is a newline
   function automatic logic ends_in_nl(input logic [WORD_W-1:0] w, input logic [3:0] m);
      logic       nl;
      logic [7:0] ch;
      nl = 1'b0;
      for (int j = 0; j < 4; j++) begin
         ch = w[31-8*j -: 8];
         if (m[3-j]) nl = (ch == CHR_NL);
      end
      return nl;
   endfunction

endpackage

`default_nettype wire

/* src/fcw_store.sv */
// main store: one-read one-write synchronous word memory with per-entry valid bits
// depends on fcw_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module fcw_store #(
   parameter int STORE_WORDS = fcw_pkg::STORE_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fcw_pkg::store_req_type        store_req,
   output logic [fcw_pkg::WORD_W-1:0]    store_rdata
);
   import fcw_pkg::*;

   localparam int                IDX_W = $clog2(STORE_WORDS);
   localparam logic [ADDR_W-1:0] LIMIT = ADDR_W'(STORE_WORDS);

   logic [WORD_W-1:0]      mem [STORE_WORDS];
   logic [STORE_WORDS-1:0] valid_ff, valid_in;
   logic [WORD_W-1:0]      rdata_ff;
   logic                   rhit_ff, rhit_in;
   logic                   rd_ok, wr_ok;
   logic [IDX_W-1:0]       rd_idx, wr_idx;

   // address decode, out-of-range accesses are masked
   assign rd_ok  = store_req.rd_en && (store_req.rd_addr < LIMIT);
   assign wr_ok  = store_req.wr_en && (store_req.wr_addr < LIMIT);
   assign rd_idx = store_req.rd_addr[IDX_W-1:0];
   assign wr_idx = store_req.wr_addr[IDX_W-1:0];

   // valid bits: cleared together, set by each write
   always_comb begin
      valid_in = valid_ff;
      if (store_req.clr) begin
         valid_in = '0;
      end else if (wr_ok) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   // a read hit needs a written entry inside the store
   always_comb begin
      rhit_in = rhit_ff;
      if (store_req.clr) begin
         rhit_in = 1'b0;
      end else if (store_req.rd_en) begin
         rhit_in = rd_ok ? valid_ff[rd_idx] : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rhit_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rhit_ff  <= rhit_in;
      end
   end

   // memory array, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_idx] <= store_req.wr_data;
      end
      if (rd_ok) begin
         rdata_ff <= mem[rd_idx];
      end
   end

   // unwritten or out-of-range entries read as zero
   assign store_rdata = rhit_ff ? rdata_ff : '0;

   `FCW_ASSERT_IMP(a_no_rw_clash, clock, reset,
      store_req.wr_en && store_req.rd_en, store_req.wr_addr != store_req.rd_addr)
   `FCW_ASSERT_IMP(a_clear_alone, clock, reset,
      store_req.clr, !store_req.wr_en && !store_req.rd_en)
   `FCW_ASSERT_NXT(a_far_read_zero, clock, reset,
      store_req.rd_en && (store_req.rd_addr >= LIMIT), store_rdata == '0)

endmodule

`default_nettype wire

/* src/fcw_seq.sv */
// sequencer: machine registers, instruction decode and result output register
// depends on fcw_pkg and assert_macros.svh; drives fcw_store
`default_nettype none
`include "assert_macros.svh"

module fcw_seq #(
   parameter int STORE_WORDS = fcw_pkg::STORE_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_op,
   input  logic [fcw_pkg::WORD_W-1:0]    req_word,
   input  logic                          req_chunk_ends_line,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fcw_pkg::WORD_W-1:0]    rsp_out_word,
   output logic [fcw_pkg::CNT_W-1:0]     rsp_out_count,
   output logic                          rsp_last,
   output logic [fcw_pkg::ST_W-1:0]      rsp_status,
   output fcw_pkg::store_req_type        store_req,
   input  logic [fcw_pkg::WORD_W-1:0]    store_rdata
);
   import fcw_pkg::*;

   localparam logic [ADDR_W-1:0] LIMIT_A = ADDR_W'(STORE_WORDS);
   localparam logic [PTR_W-1:0]  LIMIT_P = PTR_W'(STORE_WORDS);

   // machine state
   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [ADDR_W-1:0]  plen_ff, plen_in;
   logic [ADDR_W-1:0]  ic_ff, ic_in;
   logic [WORD_W-1:0]  gr_ff, gr_in;
   logic               tog_ff, tog_in;
   logic               rdone_ff, rdone_in;
   logic [PTR_W-1:0]   dptr_ff, dptr_in;
   logic [PTR_W-1:0]   blim_ff, blim_in;

   // per-instruction working registers
   oper_type           kind_ff, kind_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  pd_base_ff, pd_base_in;
   logic [3:0]         pd_idx_ff, pd_idx_in;
   logic               last_nl_ff, last_nl_in;
   logic               pend_has_ff, pend_has_in;
   logic [WORD_W-1:0]  pend_word_ff, pend_word_in;
   logic [CNT_W-1:0]   pend_cnt_ff, pend_cnt_in;
   status_type         pend_st_ff, pend_st_in;

   // result output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_word_ff, rsp_word_in;
   logic [CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic               rsp_last_ff, rsp_last_in;
   status_type         rsp_st_ff, rsp_st_in;

   logic               out_free;
   logic               emit, emit_last;
   logic [WORD_W-1:0]  emit_word;
   logic [CNT_W-1:0]   emit_cnt;
   status_type         emit_st;

   // instruction fields of the word just read
   logic [7:0]         c0, c1, c2, c3;
   logic [3:0]         d2, d3;
   logic [ADDR_W-1:0]  addr_dec, base_dec, ic_next;
   logic [PTR_W:0]     dptr_sum, blim_sum;

   // print walk: kept characters of the current word
   logic [3:0]         pd_mask;
   logic               pd_has;

   assign c0 = store_rdata[31:24];
   assign c1 = store_rdata[23:16];
   assign c2 = store_rdata[15:8];
   assign c3 = store_rdata[7:0];
   assign d2 = c2[3:0];
   assign d3 = c3[3:0];

   // one- or two-digit decimal address, tens times ten as two shifts
   always_comb begin
      base_dec = is_digit(c2) ? (({3'b000, d2} << 3) + ({3'b000, d2} << 1)) : '0;
      if (!is_digit(c2)) begin
         addr_dec = '0;
      end else if (is_digit(c3)) begin
         addr_dec = base_dec + {3'b000, d3};
      end else begin
         addr_dec = {3'b000, d2};
      end
   end

   assign ic_next  = ic_ff + ADDR_W'(1);
   assign dptr_sum = {1'b0, dptr_ff} + (PTR_W+1)'(1);
   assign blim_sum = {1'b0, blim_ff} + {1'b0, BLOCK_STEP};
   assign pd_mask  = prefix_mask(store_rdata, 1'b0);
   assign pd_has   = |pd_mask;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // next state, machine updates and store requests
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      plen_in      = plen_ff;
      ic_in        = ic_ff;
      gr_in        = gr_ff;
      tog_in       = tog_ff;
      rdone_in     = rdone_ff;
      dptr_in      = dptr_ff;
      blim_in      = blim_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      pd_base_in   = pd_base_ff;
      pd_idx_in    = pd_idx_ff;
      last_nl_in   = last_nl_ff;
      pend_has_in  = pend_has_ff;
      pend_word_in = pend_word_ff;
      pend_cnt_in  = pend_cnt_ff;
      pend_st_in   = pend_st_ff;
      store_req    = '0;
      emit         = 1'b0;
      emit_last    = 1'b0;
      emit_word    = pend_word_ff;
      emit_cnt     = pend_cnt_ff;
      emit_st      = pend_st_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in     = S_RESP;
               pend_word_in = '0;
               pend_cnt_in  = '0;
               pend_st_in   = ST_IGNORED;
               case (op_type'(req_op))
                  OP_NEW_JOB: begin
                     store_req.clr = 1'b1;
                     plen_in       = '0;
                     ic_in         = '0;
                     rdone_in      = 1'b0;
                     mode_in       = MODE_LOAD;
                     dptr_in       = '0;
                     blim_in       = '0;
                     pend_st_in    = ST_OK;
                  end
                  OP_LOAD: begin
                     if (mode_ff == MODE_LOAD) begin
                        if (plen_ff < LIMIT_A) begin
                           store_req.wr_en   = 1'b1;
                           store_req.wr_addr = plen_ff;
                           store_req.wr_data = req_word;
                           plen_in           = plen_ff + ADDR_W'(1);
                           pend_st_in        = ST_OK;
                        end else begin
                           pend_st_in = ST_DROPPED;
                        end
                     end
                  end
                  OP_RUN: begin
                     if (mode_ff == MODE_LOAD) begin
                        ic_in      = '0;
                        mode_in    = MODE_RUN;
                        pend_st_in = ST_OK;
                     end
                  end
                  OP_STEP: begin
                     if (mode_ff == MODE_RUN) begin
                        if (ic_ff >= plen_ff) begin
                           mode_in    = MODE_DONE;
                           pend_st_in = ST_END;
                        end else begin
                           store_req.rd_en   = 1'b1;
                           store_req.rd_addr = ic_ff;
                           state_in          = S_DECODE;
                        end
                     end
                  end
                  OP_DATA: begin
                     if (mode_ff == MODE_WAIT) begin
                        if (dptr_ff < LIMIT_P) begin
                           store_req.wr_en   = 1'b1;
                           store_req.wr_addr = dptr_ff[ADDR_W-1:0];
                           store_req.wr_data = req_word;
                           pend_st_in        = ST_OK;
                        end else begin
                           pend_st_in = ST_DROPPED;
                        end
                        dptr_in = dptr_sum[PTR_W] ? PTR_MAX : dptr_sum[PTR_W-1:0];
                        // line end: jump to the next block boundary
                        if (req_chunk_ends_line) begin
                           dptr_in = blim_ff;
                           blim_in = blim_sum[PTR_W] ? PTR_MAX : blim_sum[PTR_W-1:0];
                        end
                     end
                  end
                  OP_DATA_END: begin
                     if (mode_ff == MODE_WAIT) begin
                        rdone_in   = 1'b1;
                        mode_in    = MODE_RUN;
                        pend_st_in = ST_OK;
                     end
                  end
                  default: begin
                     pend_st_in = ST_IGNORED;
                  end
               endcase
            end
         end

         S_DECODE: begin
            ic_in        = ic_next;
            state_in     = S_RESP;
            pend_word_in = '0;
            pend_cnt_in  = '0;
            pend_st_in   = ST_OK;
            addr_in      = addr_dec;
            if ((c0 == CHR_L) && (c1 == CHR_R)) begin
               kind_in           = K_LR;
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = addr_dec;
               state_in          = S_OPER;
            end else if ((c0 == CHR_S) && (c1 == CHR_R)) begin
               if (addr_dec >= LIMIT_A) begin
                  pend_st_in = ST_DROPPED;
               end else begin
                  kind_in           = K_SR;
                  store_req.rd_en   = 1'b1;
                  store_req.rd_addr = addr_dec;
                  state_in          = S_OPER;
               end
            end else if ((c0 == CHR_C) && (c1 == CHR_R)) begin
               kind_in           = K_CR;
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = addr_dec;
               state_in          = S_OPER;
            end else if ((c0 == CHR_B) && (c1 == CHR_T)) begin
               if (tog_ff) ic_in = addr_dec;
            end else if ((c0 == CHR_G) && (c1 == CHR_D)) begin
               // data cards are read once per job
               if (!rdone_ff) begin
                  mode_in    = MODE_WAIT;
                  dptr_in    = {1'b0, addr_dec};
                  blim_in    = {1'b0, addr_dec} + BLOCK_STEP;
                  pend_st_in = ST_AWAIT;
               end
            end else if ((c0 == CHR_P) && (c1 == CHR_D)) begin
               pd_base_in        = base_dec;
               pd_idx_in         = '0;
               last_nl_in        = 1'b0;
               pend_has_in       = 1'b0;
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = base_dec;
               state_in          = S_PD;
            end else if (c0 == CHR_H) begin
               mode_in      = MODE_DONE;
               pend_word_in = {CHR_NL, CHR_NL, 16'h0000};
               pend_cnt_in  = CNT_W'(2);
               pend_st_in   = ST_HALTED;
            end
         end

         S_OPER: begin
            state_in = S_RESP;
            case (kind_ff)
               K_LR: begin
                  gr_in = store_rdata & char_mask(prefix_mask(store_rdata, 1'b1));
               end
               K_SR: begin
                  store_req.wr_en   = 1'b1;
                  store_req.wr_addr = addr_ff;
                  store_req.wr_data = (store_rdata & ~char_mask(prefix_mask(gr_ff, 1'b0)))
                                    | (gr_ff & char_mask(prefix_mask(gr_ff, 1'b0)));
               end
               K_CR: begin
                  tog_in = (gr_ff == store_rdata);
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         // one word a cycle unless the output register is stalled; each printed word
         // is held back by one so that the final result can carry the last mark
         S_PD: begin
            if (!(pd_has && pend_has_ff && !out_free)) begin
               if (pd_has && pend_has_ff) begin
                  emit = 1'b1;
               end
               if (pd_has) begin
                  pend_has_in  = 1'b1;
                  pend_word_in = store_rdata & char_mask(pd_mask);
                  pend_cnt_in  = mask_count(pd_mask);
                  pend_st_in   = ST_OK;
                  last_nl_in   = ends_in_nl(store_rdata, pd_mask);
               end
               if (pd_idx_ff == PD_LAST) begin
                  state_in = S_PD_END;
               end else begin
                  pd_idx_in         = pd_idx_ff + 4'd1;
                  store_req.rd_en   = 1'b1;
                  store_req.rd_addr = pd_base_ff + {3'b000, pd_idx_ff} + ADDR_W'(1);
               end
            end
         end

         // flush the held word, then the closing newline if one is due
         S_PD_END: begin
            if (out_free) begin
               emit = 1'b1;
               if (pend_has_ff) begin
                  emit_last   = last_nl_ff;
                  pend_has_in = 1'b0;
                  if (last_nl_ff) state_in = S_IDLE;
               end else begin
                  emit_word = {CHR_NL, 24'h000000};
                  emit_cnt  = CNT_W'(1);
                  emit_st   = ST_OK;
                  emit_last = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end

         S_RESP: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register loads a beat whenever it is empty or being taken
   always_comb begin
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_word_in  = rsp_word_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_st_in    = rsp_st_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = emit_word;
         rsp_cnt_in   = emit_cnt;
         rsp_last_in  = emit_last;
         rsp_st_in    = emit_st;
      end
   end

   // control and machine registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_LOAD;
         plen_ff      <= '0;
         ic_ff        <= '0;
         gr_ff        <= '0;
         tog_ff       <= 1'b0;
         rdone_ff     <= 1'b0;
         dptr_ff      <= '0;
         blim_ff      <= '0;
         pend_has_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         plen_ff      <= plen_in;
         ic_ff        <= ic_in;
         gr_ff        <= gr_in;
         tog_ff       <= tog_in;
         rdone_ff     <= rdone_in;
         dptr_ff      <= dptr_in;
         blim_ff      <= blim_in;
         pend_has_ff  <= pend_has_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      addr_ff      <= addr_in;
      pd_base_ff   <= pd_base_in;
      pd_idx_ff    <= pd_idx_in;
      last_nl_ff   <= last_nl_in;
      pend_word_ff <= pend_word_in;
      pend_cnt_ff  <= pend_cnt_in;
      pend_st_ff   <= pend_st_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_st_ff    <= rsp_st_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_word  = rsp_word_ff;
   assign rsp_out_count = rsp_cnt_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_status    = rsp_st_ff;

   `FCW_ASSERT_IMP(a_wait_before_read_done, clock, reset,
      mode_ff == MODE_WAIT, !rdone_ff)
   `FCW_ASSERT_IMP(a_program_fits, clock, reset,
      1'b1, plen_ff <= LIMIT_A)
   `FCW_ASSERT_IMP(a_pd_newline_due, clock, reset,
      (state_ff == S_PD_END) && !pend_has_ff, !last_nl_ff)

endmodule

`default_nettype wire

/* src/four_char_word_machine_executor_top.sv */
// four-character word machine executor: sequencer around a word store with a registered read
// one request at a time: req_stall holds further requests until the last result beat is registered
// reset (synchronous, active high) empties the store through its valid bits
// depends on fcw_pkg, fcw_seq and fcw_store
`default_nettype none

module four_char_word_machine_executor_top #(
   parameter int STORE_WORDS = fcw_pkg::STORE_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_op,
   input  logic [fcw_pkg::WORD_W-1:0]    req_word,
   input  logic                          req_chunk_ends_line,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fcw_pkg::WORD_W-1:0]    rsp_out_word,
   output logic [fcw_pkg::CNT_W-1:0]     rsp_out_count,
   output logic                          rsp_last,
   output logic [fcw_pkg::ST_W-1:0]      rsp_status
);
   import fcw_pkg::*;

   store_req_type     store_req;
   logic [WORD_W-1:0] store_rdata;

   // instruction sequencer and result register
   fcw_seq #(
      .STORE_WORDS (STORE_WORDS)
   ) u_seq (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_word            (req_word),
      .req_chunk_ends_line (req_chunk_ends_line),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_word        (rsp_out_word),
      .rsp_out_count       (rsp_out_count),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status),
      .store_req           (store_req),
      .store_rdata         (store_rdata)
   );

   // main store
   fcw_store #(
      .STORE_WORDS (STORE_WORDS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .store_req   (store_req),
      .store_rdata (store_rdata)
   );

endmodule

`default_nettype wire

/* verif/four_char_word_machine_executor_checker.sv */
// checker for the word machine executor: predicts every result beat and compares
// watches the req_ and rsp_ channels only; depends on fcw_pkg for codes and widths
`timescale 1ns / 100ps

module four_char_word_machine_executor_checker #(
   parameter int WORDS = fcw_pkg::STORE_WORDS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [2:0]                 req_op,
   input  logic [fcw_pkg::WORD_W-1:0] req_word,
   input  logic                       req_chunk_ends_line,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [fcw_pkg::WORD_W-1:0] rsp_out_word,
   input  logic [fcw_pkg::CNT_W-1:0]  rsp_out_count,
   input  logic                       rsp_last,
   input  logic [fcw_pkg::ST_W-1:0]   rsp_status,
   output int                         fail_count,
   output int                         beats_waiting,
   output int                         work_items,
   output int                         beats_seen,
   output int                         chars_printed,
   output fcw_pkg::mode_type          pred_mode
);
   import fcw_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] text;
      logic [CNT_W-1:0]  n_chars;
      logic              last;
      status_type        status;
   } beat_type;

   // shadow machine state
   logic [WORD_W-1:0] store_img [WORDS];
   logic [6:0]        prog_len;
   logic [6:0]        instr_ctr;
   logic [WORD_W-1:0] acc_reg;
   logic              flag_tog;
   logic              cards_read;
   mode_type          mode;
   logic [PTR_W-1:0]  card_ptr;
   logic [PTR_W-1:0]  card_limit;

   beat_type beats_due[$];

   assign pred_mode = mode;

   function automatic logic [7:0] char_of(input logic [WORD_W-1:0] w, input int i);
      return w[31-8*i -: 8];
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CHR_ZERO) && (c <= CHR_NINE);
   endfunction

   function automatic logic [WORD_W-1:0] fetch(input int unsigned a);
      return (a < WORDS) ? store_img[a] : '0;
   endfunction

   function automatic logic [PTR_W-1:0] sat_add8(input logic [PTR_W-1:0] v,
                                                  input int unsigned d);
      int unsigned r;
      r = v + d;
      return (r > 255) ? PTR_MAX : r[PTR_W-1:0];
   endfunction

   task automatic queue_beat(input logic [WORD_W-1:0] text, input logic [CNT_W-1:0] n,
                             input status_type st);
      beat_type b;
      b.text    = text;
      b.n_chars = n;
      b.last    = 1'b0;
      b.status  = st;
      beats_due.push_back(b);
   endtask

   task automatic clear_job();
      for (int i = 0; i < WORDS; i++) store_img[i] = '0;
      prog_len   = '0;
      instr_ctr  = '0;
      cards_read = 1'b0;
      mode       = MODE_LOAD;
      card_ptr   = '0;
      card_limit = '0;
   endtask

   // one instruction of the running program
   task automatic exec_instruction();
      logic [WORD_W-1:0] ir, w, acc;
      logic [7:0]        c0, c1, c2, c3, ch;
      logic [6:0]        nxt;
      int unsigned       addr, base, n;
      logic              nl_last;
      if (instr_ctr >= prog_len) begin
         mode = MODE_DONE;
         queue_beat('0, '0, ST_END);
         return;
      end
      ir = fetch(instr_ctr);
      c0 = char_of(ir, 0);
      c1 = char_of(ir, 1);
      c2 = char_of(ir, 2);
      c3 = char_of(ir, 3);
      addr = 0;
      if (is_dec(c2)) begin
         addr = c2 - CHR_ZERO;
         if (is_dec(c3)) addr = addr * 10 + (c3 - CHR_ZERO);
      end
      nxt = instr_ctr + 7'd1;

      if (c0 == CHR_L && c1 == CHR_R) begin
         // load stops at the first nul or newline
         w   = fetch(addr);
         acc = '0;
         for (int j = 0; j < 4; j++) begin
            ch = char_of(w, j);
            if (ch == CHR_NUL || ch == CHR_NL) break;
            acc[31-8*j -: 8] = ch;
         end
         acc_reg = acc;
      end else if (c0 == CHR_S && c1 == CHR_R) begin
         if (addr >= WORDS) begin
            instr_ctr = nxt;
            queue_beat('0, '0, ST_DROPPED);
            return;
         end
         // only the register's leading characters overwrite the word
         w = store_img[addr];
         for (int j = 0; j < 4; j++) begin
            ch = char_of(acc_reg, j);
            if (ch == CHR_NUL) break;
            w[31-8*j -: 8] = ch;
         end
         store_img[addr] = w;
      end else if (c0 == CHR_C && c1 == CHR_R) begin
         flag_tog = (acc_reg == fetch(addr));
      end else if (c0 == CHR_B && c1 == CHR_T) begin
         if (flag_tog) nxt = addr[6:0];
      end else if (c0 == CHR_G && c1 == CHR_D) begin
         if (!cards_read) begin
            mode       = MODE_WAIT;
            card_ptr   = addr[PTR_W-1:0];
            card_limit = PTR_W'(addr) + BLOCK_STEP;
            instr_ctr  = nxt;
            queue_beat('0, '0, ST_AWAIT);
            return;
         end
      end else if (c0 == CHR_P && c1 == CHR_D) begin
         // ten words of one block, each up to its first nul
         base    = is_dec(c2) ? (c2 - CHR_ZERO) * 10 : 0;
         nl_last = 1'b0;
         for (int j = 0; j < 10; j++) begin
            w   = fetch(base + j);
            acc = '0;
            n   = 0;
            while (n < 4 && char_of(w, n) != CHR_NUL) begin
               acc[31-8*n -: 8] = char_of(w, n);
               nl_last = (char_of(w, n) == CHR_NL);
               n++;
            end
            if (n > 0) begin
               queue_beat(acc, n[CNT_W-1:0], ST_OK);
               chars_printed += n;
            end
         end
         if (!nl_last) queue_beat({CHR_NL, 24'h0}, 3'd1, ST_OK);
         instr_ctr = nxt;
         return;
      end else if (c0 == CHR_H) begin
         mode      = MODE_DONE;
         instr_ctr = nxt;
         queue_beat({CHR_NL, CHR_NL, 16'h0}, 3'd2, ST_HALTED);
         return;
      end
      instr_ctr = nxt;
      queue_beat('0, '0, ST_OK);
   endtask

   // one accepted request beat
   task automatic predict_item(input logic [2:0] op, input logic [WORD_W-1:0] w,
                               input logic ends);
      status_type st;
      beat_type   b;
      st = ST_IGNORED;
      if (op == OP_STEP && mode == MODE_RUN) begin
         exec_instruction();
         st = ST_OK;
      end else begin
         case (op)
            OP_NEW_JOB: begin
               clear_job();
               st = ST_OK;
            end
            OP_LOAD: begin
               if (mode == MODE_LOAD) begin
                  if (prog_len < WORDS) begin
                     store_img[prog_len] = w;
                     prog_len = prog_len + 7'd1;
                     st = ST_OK;
                  end else begin
                     st = ST_DROPPED;
                  end
               end
            end
            OP_RUN: begin
               if (mode == MODE_LOAD) begin
                  instr_ctr = '0;
                  mode      = MODE_RUN;
                  st        = ST_OK;
               end
            end
            OP_DATA: begin
               if (mode == MODE_WAIT) begin
                  if (card_ptr < WORDS) begin
                     store_img[card_ptr] = w;
                     st = ST_OK;
                  end else begin
                     st = ST_DROPPED;
                  end
                  card_ptr = sat_add8(card_ptr, 1);
                  if (ends) begin
                     card_ptr   = card_limit;
                     card_limit = sat_add8(card_limit, BLOCK_STEP);
                  end
               end
            end
            OP_DATA_END: begin
               if (mode == MODE_WAIT) begin
                  cards_read = 1'b1;
                  mode       = MODE_RUN;
                  st         = ST_OK;
               end
            end
            default: ;
         endcase
         queue_beat('0, '0, st);
      end
      if (st != ST_IGNORED) work_items++;
      // the item's final beat carries last
      b      = beats_due.pop_back();
      b.last = 1'b1;
      beats_due.push_back(b);
   endtask

   // compare a result beat with the oldest prediction
   task automatic compare_beat();
      beat_type b;
      if (beats_due.size() == 0) begin
         $error("unexpected result beat: out_word %h out_count %0d status %0d",
                rsp_out_word, rsp_out_count, rsp_status);
         fail_count++;
         return;
      end
      b = beats_due.pop_front();
      beats_seen++;
      if (rsp_out_word !== b.text) begin
         $error("out_word mismatch: expected %h, actual %h", b.text, rsp_out_word);
         fail_count++;
      end
      if (rsp_out_count !== b.n_chars) begin
         $error("out_count mismatch: expected %0d, actual %0d", b.n_chars, rsp_out_count);
         fail_count++;
      end
      if (rsp_last !== b.last) begin
         $error("last mismatch: expected %0d, actual %0d", b.last, rsp_last);
         fail_count++;
      end
      if (rsp_status !== b.status) begin
         $error("status mismatch: expected %0d, actual %0d", b.status, rsp_status);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_job();
         acc_reg       = '0;
         flag_tog      = 1'b0;
         beats_due.delete();
         fail_count    = 0;
         work_items    = 0;
         beats_seen    = 0;
         chars_printed = 0;
      end else begin
         if (rsp_valid && !rsp_stall) compare_beat();
         if (req_valid && !req_stall) predict_item(req_op, req_word, req_chunk_ends_line);
      end
      beats_waiting = beats_due.size();
   end

endmodule

/* verif/four_char_word_machine_executor_top_tb.sv */
// testbench top for the word machine executor: clock, reset, stimulus and verdict
// depends on fcw_pkg, the executor rtl and four_char_word_machine_executor_checker
`timescale 1ns / 100ps

module four_char_word_machine_executor_top_tb;
   import fcw_pkg::*;

   localparam int ITEM_TARGET = 400;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;
   localparam int STEP_CAP    = 40;

   // op codes outside the defined set
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [2:0]        req_op;
   logic [WORD_W-1:0] req_word;
   logic              req_chunk_ends_line;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [WORD_W-1:0] rsp_out_word;
   logic [CNT_W-1:0]  rsp_out_count;
   logic              rsp_last;
   logic [ST_W-1:0]   rsp_status;

   int       fail_count;
   int       beats_waiting;
   int       work_items;
   int       beats_seen;
   int       chars_printed;
   mode_type pred_mode;

   int   send_idle_pct;
   int   recv_stall_pct;
   logic hold_go;
   logic holding;
   bit   overflow_job_done;

   four_char_word_machine_executor_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_word            (req_word),
      .req_chunk_ends_line (req_chunk_ends_line),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_word        (rsp_out_word),
      .rsp_out_count       (rsp_out_count),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status)
   );

   four_char_word_machine_executor_checker machine_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_word            (req_word),
      .req_chunk_ends_line (req_chunk_ends_line),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_word        (rsp_out_word),
      .rsp_out_count       (rsp_out_count),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status),
      .fail_count          (fail_count),
      .beats_waiting       (beats_waiting),
      .work_items          (work_items),
      .beats_seen          (beats_seen),
      .chars_printed       (chars_printed),
      .pred_mode           (pred_mode)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run guard
   initial begin
      #8_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver stalls, forced high during the hold-off
   always @(negedge clock) begin
      if (holding) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // one long hold-off so the block backs up into its input
   initial begin
      holding = 1'b0;
      wait (hold_go);
      @(negedge clock);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      holding <= 1'b0;
   end

   // offer one beat from a falling edge, return at the falling edge after acceptance
   task automatic send_beat(input logic [2:0] op, input logic [WORD_W-1:0] w,
                            input logic ends);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= op;
      req_word            <= w;
      req_chunk_ends_line <= ends;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [7:0] card_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return CHR_NUL;
      if (pick < 25) return CHR_NL;
      if (pick < 40) return 8'($urandom);
      if (pick < 55) return CHR_ZERO + 8'($urandom_range(9));
      return 8'h41 + 8'($urandom_range(25));
   endfunction

   function automatic logic [WORD_W-1:0] card_word();
      if ($urandom_range(99) < 15) return $urandom;
      return {card_char(), card_char(), card_char(), card_char()};
   endfunction

   // program word: mostly well-formed instructions, some junk
   function automatic logic [WORD_W-1:0] make_instr();
      int         pick;
      int         unit_pick;
      logic [7:0] c2, c3;
      pick      = $urandom_range(99);
      unit_pick = $urandom_range(9);
      c2 = ($urandom_range(9) != 0) ? CHR_ZERO + 8'($urandom_range(9)) : 8'($urandom);
      if (unit_pick < 8) c3 = CHR_ZERO + 8'($urandom_range(9));
      else if (unit_pick == 8) c3 = CHR_NUL;
      else c3 = 8'($urandom);
      if (pick < 12) return {CHR_L, CHR_R, c2, c3};
      if (pick < 24) return {CHR_S, CHR_R, c2, c3};
      if (pick < 34) return {CHR_C, CHR_R, c2, c3};
      if (pick < 42) return {CHR_B, CHR_T, c2, c3};
      if (pick < 57) return {CHR_G, CHR_D, c2, c3};
      if (pick < 75) return {CHR_P, CHR_D, c2, c3};
      if (pick < 83) return {CHR_H, 8'($urandom), c2, c3};
      return $urandom;
   endfunction

   // a beat the block should ignore in its present mode
   task automatic send_noise();
      logic [2:0] op;
      int         pick;
      pick = $urandom_range(4);
      case (pick)
         0: op = (pred_mode == MODE_LOAD) ? OP_STEP : OP_LOAD;
         1: op = (pred_mode == MODE_WAIT) ? OP_STEP : OP_DATA_END;
         2: op = (pred_mode == MODE_LOAD) ? OP_DATA : OP_RUN;
         3: op = OP_SPARE_LO;
         default: op = OP_SPARE_HI;
      endcase
      if (pred_mode == MODE_DONE && pick < 3) op = OP_STEP;
      send_beat(op, $urandom, 1'($urandom));
   endtask

   // data cards for a pending GD, now and then a long run of line ends
   task automatic feed_cards();
      int burst;
      int n;
      burst = ($urandom_range(99) < 6);
      n     = burst ? 30 : $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 5) send_noise();
         send_beat(OP_DATA, card_word(), burst ? 1'b1 : ($urandom_range(99) < 35));
      end
      send_beat(OP_DATA_END, $urandom, 1'($urandom));
   endtask

   // new job, program load, then mostly a run and steps until it ends or the cap is hit
   task automatic run_job();
      int n_words;
      int steps;
      send_beat(OP_NEW_JOB, $urandom, 1'($urandom));
      if (!overflow_job_done && work_items > 120) begin
         n_words = STORE_WORDS_DEF + 2;
         overflow_job_done = 1'b1;
      end else begin
         n_words = $urandom_range(3, 16);
      end
      for (int i = 0; i < n_words; i++) begin
         if ($urandom_range(99) < 10) send_noise();
         send_beat(OP_LOAD, make_instr(), 1'($urandom));
      end
      if ($urandom_range(99) < 5) return;
      send_beat(OP_RUN, $urandom, 1'($urandom));
      steps = 0;
      while (steps < STEP_CAP && pred_mode != MODE_DONE) begin
         if ($urandom_range(99) < 8) send_noise();
         if (pred_mode == MODE_WAIT) begin
            feed_cards();
         end else begin
            send_beat(OP_STEP, $urandom, 1'($urandom));
            steps++;
         end
      end
      if ($urandom_range(99) < 30) send_noise();
   endtask

   // short directed program: wrong-mode beats, GD near the top of the store,
   // a dropped card write, PD of that block, LR/SR/CR/BT, a spent GD and a halt
   task automatic directed_part();
      send_beat(OP_STEP, 32'hFFFF_FFFF, 1'b1);
      send_beat(OP_DATA, 32'h0000_0000, 1'b0);
      send_beat(OP_SPARE_LO, 32'hA5A5_5A5A, 1'b1);
      send_beat(OP_SPARE_HI, 32'h5A5A_A5A5, 1'b0);
      send_beat(OP_NEW_JOB, 32'hFFFF_FFFF, 1'b1);
      send_beat(OP_LOAD, "GD95", 1'b0);
      send_beat(OP_LOAD, "PD9?", 1'b0);
      send_beat(OP_LOAD, "LR95", 1'b0);
      send_beat(OP_LOAD, {"SR0", CHR_NUL}, 1'b0);
      send_beat(OP_LOAD, "CR95", 1'b0);
      send_beat(OP_LOAD, "BT07", 1'b0);
      send_beat(OP_LOAD, "GDx1", 1'b0);
      send_beat(OP_LOAD, {CHR_H, 24'h0}, 1'b0);
      send_beat(OP_RUN, 32'h0000_0000, 1'b0);
      send_beat(OP_STEP, 32'h0000_0000, 1'b0);
      send_beat(OP_DATA, {"AB", CHR_NL, CHR_NUL}, 1'b0);
      send_beat(OP_DATA, 32'hFFFF_FFFF, 1'b1);
      send_beat(OP_DATA, "ZZZZ", 1'b0);
      send_beat(OP_DATA_END, 32'h0000_0000, 1'b0);
      repeat (8) send_beat(OP_STEP, 32'h0000_0000, 1'b0);
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_op              = OP_NEW_JOB;
      req_word            = '0;
      req_chunk_ends_line = 1'b0;
      hold_go             = 1'b0;
      overflow_job_done   = 1'b0;
      send_idle_pct       = 24;
      recv_stall_pct      = 74;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      directed_part();

      // idling phases: sender light and receiver heavy, then swapped, then none
      while (work_items < ITEM_TARGET) begin
         if (work_items >= 2 * ITEM_TARGET / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            hold_go        = 1'b1;
         end else if (work_items >= ITEM_TARGET / 3) begin
            send_idle_pct  = 74;
            recv_stall_pct = 24;
         end
         run_job();
      end
      req_valid <= 1'b0;

      // drain
      wait (beats_waiting == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d working beats in, %0d result beats checked, %0d chars printed",
               work_items, beats_seen, chars_printed);
      $display("jobs ran with card reads, prints, halts, a full program and a receiver hold-off");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
